[src/rrd_pkg.sv]
// Shared types and constants of the ray reflect/refract direction unit.
package rrd_pkg;

	localparam int FRAC_BITS = 14;
	localparam int ETA_FRAC  = FRAC_BITS - 1;

	localparam logic [14:0] ETA_MAX = 15'h7fff;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic signed [15:0] cos_incidence;
		logic        [14:0] refr_index;
	} cmd_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [15:0] out_z;
		logic               total_reflection;
		logic        [14:0] eta;
	} res_t;

	localparam logic mode_reflect = 1'b0;
	localparam logic mode_refract = 1'b1;

endpackage

[src/ray_reflect_refract_direction.sv]
// Top level: pipelined specular reflection / Snell refraction direction unit.
//
// One hit enters per clock whenever start is high; busy is tied low because the
// datapath is a fixed 18-stage pipeline with no feedback. Each accepted beat comes
// back on result, marked by a one-cycle done strobe, in the order taken; the
// receiver cannot stall so nothing is held back. The depth is set by the
// entering-ratio divider (five stages of three quotient bits each) and the square
// root of the Snell radicand (six stages of three root bits each), plus the
// multiply and rounding stages around them. Reflect mode gives d - 2*c*N with
// eta 0; refract mode picks the side from the sign of the cosine, raises
// total_reflection with a zero direction when the radicand is not positive,
// and saturates every component to the Q2.14 range.
module ray_reflect_refract_direction (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  rrd_pkg::cmd_t cmd,
	output logic         done,
	output rrd_pkg::res_t result
);
	import rrd_pkg::*;

	localparam int LAT = 18;

	localparam logic signed [36:0] HALF_F   = 37'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [36:0] ONE_F    = 37'sd1 <<< FRAC_BITS;
	localparam logic signed [31:0] ONE_SQ   = 32'sd1 <<< (2 * FRAC_BITS);
	localparam logic        [26:0] DIV_ONE  = 27'd1 << (2 * ETA_FRAC);
	localparam logic        [30:0] HALF_E2  = 31'd1 << (2 * ETA_FRAC - FRAC_BITS - 1);
	localparam logic        [32:0] HALF_EC  = 33'd1 << (ETA_FRAC - 1);

	typedef struct packed {
		logic        [26:0] rem;
		logic        [14:0] q;
	} div_t;

	typedef struct packed {
		logic        [35:0] rem;
		logic        [17:0] r;
	} sqr_t;

	typedef struct packed {
		logic               mode;
		logic               enter;
		logic [2:0][15:0]   n;
		logic [2:0][15:0]   d;
		logic        [14:0] idx;
		logic        [16:0] cabs;
		logic [2:0][32:0]   rp;
		logic        [30:0] csq;
		logic [2:0][15:0]   rout;
		logic        [16:0] qv;
		div_t               dv;
		logic               dovf;
		logic        [14:0] eta;
		logic        [29:0] ee;
		logic        [31:0] ec;
		logic        [18:0] eta2;
		logic        [17:0] mrnd;
		logic        [36:0] tp;
		logic               tir;
		sqr_t               sq;
		logic [2:0][33:0]   ed;
		logic [2:0][35:0]   mn;
	} pipe_t;

	function automatic logic [15:0] sat16(input logic signed [39:0] v);
		logic [15:0] o;
		if (v > 40'sd32767) begin
			o = 16'h7fff;
		end else if (v < -40'sd32768) begin
			o = 16'h8000;
		end else begin
			o = v[15:0];
		end
		return o;
	endfunction

	// Three restoring-division steps, quotient bits hi down to hi-2.
	function automatic div_t div3(input div_t a, input logic [14:0] idx, input int hi);
		div_t        o;
		logic [29:0] sub;
		o = a;
		for (int j = 0; j < 3; j++) begin
			sub = 30'(idx) << (hi - j);
			if (30'(o.rem) >= sub) begin
				o.rem = 27'(30'(o.rem) - sub);
				o.q[hi - j] = 1'b1;
			end
		end
		return o;
	endfunction

	// Three digit-by-digit square root steps, root bits hi down to hi-2.
	function automatic sqr_t sqrt3(input sqr_t a, input int hi);
		sqr_t        o;
		logic [35:0] trial;
		o = a;
		for (int j = 0; j < 3; j++) begin
			trial = (36'(o.r) << (hi - j + 1)) + (36'd1 << (2 * (hi - j)));
			if (o.rem >= trial) begin
				o.rem = o.rem - trial;
				o.r[hi - j] = 1'b1;
			end
		end
		return o;
	endfunction

	pipe_t p_s1, p_s2, p_s3, p_s4, p_s5, p_s6, p_s7, p_s8, p_s9;
	pipe_t p_s10, p_s11, p_s12, p_s13, p_s14, p_s15, p_s16, p_s17;
	pipe_t n1, n2, n7, n8, n9, n10, n17;
	pipe_t n3, n4, n5, n6, n11, n12, n13, n14, n15, n16;
	res_t  res_s18, n18;
	logic [LAT-1:0] vld_q;

	assign busy = 1'b0;

	// Stage 1: capture, fold cosine sign, reflect and cosine products, divider setup.
	always_comb begin
		logic signed [16:0] c17;
		logic signed [32:0] pr;
		logic        [26:0] num;
		n1 = '0;
		c17 = 17'(cmd.cos_incidence);
		n1.mode  = cmd.mode;
		n1.enter = (cmd.mode == mode_refract) && cmd.cos_incidence[15];
		n1.n = {cmd.normal_z, cmd.normal_y, cmd.normal_x};
		n1.d = {cmd.dir_z, cmd.dir_y, cmd.dir_x};
		n1.idx = cmd.refr_index;
		n1.cabs = c17[16] ? 17'(-c17) : 17'(c17);
		for (int i = 0; i < 3; i++) begin
			pr = 33'(cmd.cos_incidence) * 33'($signed(n1.n[i]));
			n1.rp[i] = pr <<< 1;
		end
		n1.csq = 31'(34'(n1.cabs) * 34'(n1.cabs));
		num = DIV_ONE + 27'(cmd.refr_index >> 1);
		n1.dovf = (cmd.refr_index == '0) || (30'(num) >= {cmd.refr_index, 15'b0});
		n1.dv.rem = num;
		n1.dv.q = '0;
	end

	// Stage 2: first divider digits, 1 - c^2, finished reflect result.
	always_comb begin
		logic signed [31:0] qd;
		logic signed [32:0] rr;
		logic signed [39:0] df;
		n2 = p_s1;
		n2.dv = div3(p_s1.dv, p_s1.idx, 14);
		qd = ONE_SQ - 32'(p_s1.csq) + 32'(HALF_F);
		n2.qv = 17'(qd >>> FRAC_BITS);
		for (int i = 0; i < 3; i++) begin
			rr = ($signed(p_s1.rp[i]) + 33'(HALF_F)) >>> FRAC_BITS;
			df = 40'($signed(p_s1.d[i])) - 40'(rr);
			n2.rout[i] = sat16(df);
		end
	end

	// Stages 3 to 6: remaining divider digits.
	always_comb begin
		n3 = p_s2;
		n3.dv = div3(p_s2.dv, p_s2.idx, 11);
		n4 = p_s3;
		n4.dv = div3(p_s3.dv, p_s3.idx, 8);
		n5 = p_s4;
		n5.dv = div3(p_s4.dv, p_s4.idx, 5);
		n6 = p_s5;
		n6.dv = div3(p_s5.dv, p_s5.idx, 2);
	end

	// Stage 7: pick the ratio, square it and scale the cosine.
	always_comb begin
		logic [14:0] e;
		n7 = p_s6;
		if (p_s6.enter) begin
			e = p_s6.dovf ? ETA_MAX : p_s6.dv.q;
		end else begin
			e = p_s6.idx;
		end
		n7.eta = e;
		n7.ee  = 30'(e) * 30'(e);
		n7.ec  = 32'(e) * 32'(p_s6.cabs);
	end

	// Stage 8: round eta^2 and eta*c.
	always_comb begin
		n8 = p_s7;
		n8.eta2 = 19'((31'(p_s7.ee) + HALF_E2) >> (2 * ETA_FRAC - FRAC_BITS));
		n8.mrnd = 18'((33'(p_s7.ec) + HALF_EC) >> ETA_FRAC);
	end

	// Stage 9: eta^2 * (1 - c^2).
	always_comb begin
		logic signed [36:0] a, b;
		n9 = p_s8;
		a = 37'($signed({1'b0, p_s8.eta2}));
		b = 37'($signed(p_s8.qv));
		n9.tp = a * b;
	end

	// Stage 10: radicand k, total reflection test, root setup.
	always_comb begin
		logic signed [36:0] t, k;
		n10 = p_s9;
		t = ($signed(p_s9.tp) + HALF_F) >>> FRAC_BITS;
		k = ONE_F - t;
		n10.tir = (k <= 37'sd0);
		n10.sq.rem = n10.tir ? '0 : (36'(k[19:0]) << FRAC_BITS);
		n10.sq.r = '0;
	end

	// Stages 11 to 16: root digits, three per stage.
	always_comb begin
		n11 = p_s10;
		n11.sq = sqrt3(p_s10.sq, 17);
		n12 = p_s11;
		n12.sq = sqrt3(p_s11.sq, 14);
		n13 = p_s12;
		n13.sq = sqrt3(p_s12.sq, 11);
		n14 = p_s13;
		n14.sq = sqrt3(p_s13.sq, 8);
		n15 = p_s14;
		n15.sq = sqrt3(p_s14.sq, 5);
		n16 = p_s15;
		n16.sq = sqrt3(p_s15.sq, 2);
	end

	// Stage 17: m = eta*c - cosT, flip for leaving rays, both product sets.
	always_comb begin
		logic signed [19:0] m, ms;
		n17 = p_s16;
		m  = $signed(20'(p_s16.mrnd)) - $signed(20'(p_s16.sq.r[16:0]));
		ms = p_s16.enter ? m : -m;
		for (int i = 0; i < 3; i++) begin
			n17.ed[i] = (34'($signed({1'b0, p_s16.eta})) * 34'($signed(p_s16.d[i]))) <<< 1;
			n17.mn[i] = 36'(ms) * 36'($signed(p_s16.n[i]));
		end
	end

	// Stage 18: sum, round, saturate and select the result.
	always_comb begin
		logic signed [39:0] s;
		logic [2:0][15:0]   o;
		for (int i = 0; i < 3; i++) begin
			s = 40'($signed(p_s17.ed[i])) + 40'($signed(p_s17.mn[i])) + 40'(HALF_F);
			o[i] = sat16(s >>> FRAC_BITS);
		end
		n18 = '0;
		if (p_s17.mode == mode_reflect) begin
			n18.out_x = p_s17.rout[0];
			n18.out_y = p_s17.rout[1];
			n18.out_z = p_s17.rout[2];
		end else if (p_s17.tir) begin
			n18.total_reflection = 1'b1;
			n18.eta = p_s17.eta;
		end else begin
			n18.out_x = o[0];
			n18.out_y = o[1];
			n18.out_z = o[2];
			n18.eta = p_s17.eta;
		end
	end

	// Advance the payload every cycle; valid bits mark which stages hold beats.
	always_ff @(posedge clk) begin
		p_s1  <= n1;
		p_s2  <= n2;
		p_s3  <= n3;
		p_s4  <= n4;
		p_s5  <= n5;
		p_s6  <= n6;
		p_s7  <= n7;
		p_s8  <= n8;
		p_s9  <= n9;
		p_s10 <= n10;
		p_s11 <= n11;
		p_s12 <= n12;
		p_s13 <= n13;
		p_s14 <= n14;
		p_s15 <= n15;
		p_s16 <= n16;
		p_s17 <= n17;
		res_s18 <= n18;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end

	assign done   = vld_q[LAT-1];
	assign result = res_s18;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted beat did not return after the pipeline depth");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching accepted beat");

	a_tir_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.total_reflection) |->
		(result.out_x == '0 && result.out_y == '0 && result.out_z == '0))
		else $error("total reflection with a nonzero direction");

	a_tir_eta: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.total_reflection) |-> (result.eta != '0))
		else $error("total reflection reported with a zero ratio");

endmodule

[dv/tb.sv]
// Testbench for the ray reflect/refract direction unit: random and directed hits, checked in order.
module tb;
	import rrd_pkg::*;

	// Predicted direction unit: fixed-point reflect / Snell refract.
	class ray_dir_scoreboard;
		res_t pending[$];
		int   errors;

		function automatic longint round_shift(longint v, int s);
			longint w;
			w = v + (longint'(1) << (s - 1));
			return w >>> s;
		endfunction

		function automatic logic [15:0] clamp16(longint v);
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			return v[15:0];
		endfunction

		function automatic longint root64(longint v);
			longint r, b;
			r = 0;
			b = longint'(1) << 60;
			while (b > v) b = b >>> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >>> 1) + b;
				end else begin
					r = r >>> 1;
				end
				b = b >>> 2;
			end
			return r;
		endfunction

		function automatic res_t predict_hit(cmd_t h);
			res_t   r;
			longint nv[3], dv[3], c, e, q, e2, t, k, ct, m;
			nv[0] = longint'(h.normal_x);
			nv[1] = longint'(h.normal_y);
			nv[2] = longint'(h.normal_z);
			dv[0] = longint'(h.dir_x);
			dv[1] = longint'(h.dir_y);
			dv[2] = longint'(h.dir_z);
			c = longint'(h.cos_incidence);
			r = '0;
			if (h.mode == mode_reflect) begin
				r.out_x = clamp16(dv[0] - round_shift(2 * c * nv[0], FRAC_BITS));
				r.out_y = clamp16(dv[1] - round_shift(2 * c * nv[1], FRAC_BITS));
				r.out_z = clamp16(dv[2] - round_shift(2 * c * nv[2], FRAC_BITS));
				return r;
			end
			if (c < 0) begin
				if (h.refr_index == 0) e = 32767;
				else begin
					e = ((longint'(1) << (2 * ETA_FRAC)) + (h.refr_index >> 1)) / h.refr_index;
					if (e > 32767) e = 32767;
				end
				c = -c;
			end else begin
				e = longint'(h.refr_index);
				for (int i = 0; i < 3; i++) nv[i] = -nv[i];
			end
			q  = round_shift((longint'(1) << (2 * FRAC_BITS)) - c * c, FRAC_BITS);
			e2 = round_shift(e * e, 2 * ETA_FRAC - FRAC_BITS);
			t  = round_shift(e2 * q, FRAC_BITS);
			k  = (longint'(1) << FRAC_BITS) - t;
			r.eta = e[14:0];
			if (k <= 0) begin
				r.total_reflection = 1'b1;
				return r;
			end
			ct = root64(k << FRAC_BITS);
			m  = round_shift(e * c, ETA_FRAC) - ct;
			r.out_x = clamp16(round_shift(2 * e * dv[0] + m * nv[0], FRAC_BITS));
			r.out_y = clamp16(round_shift(2 * e * dv[1] + m * nv[1], FRAC_BITS));
			r.out_z = clamp16(round_shift(2 * e * dv[2] + m * nv[2], FRAC_BITS));
			return r;
		endfunction

		function void note_hit(cmd_t h);
			pending.push_back(predict_hit(h));
		endfunction

		function void check_direction(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected beat %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.out_x !== want.out_x)
				$display("%0t: out_x exp %0d got %0d", $time, want.out_x, got.out_x);
			if (got.out_y !== want.out_y)
				$display("%0t: out_y exp %0d got %0d", $time, want.out_y, got.out_y);
			if (got.out_z !== want.out_z)
				$display("%0t: out_z exp %0d got %0d", $time, want.out_z, got.out_z);
			if (got.total_reflection !== want.total_reflection)
				$display("%0t: total_reflection exp %0b got %0b", $time,
					want.total_reflection, got.total_reflection);
			if (got.eta !== want.eta)
				$display("%0t: eta exp %0d got %0d", $time, want.eta, got.eta);
			if (got !== want) errors++;
		endfunction
	endclass

	localparam int STALL_LIMIT = 2000;

	logic  clk, arst_n, start, busy, done;
	cmd_t  cmd;
	res_t  result;
	int    send_gap_pct;
	int    idle_cycles;
	bit    timed_out;
	ray_dir_scoreboard board;

	ray_reflect_refract_direction dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sample on the edge: accepted inputs go to the predictor, strobed results get checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) board.note_hit(cmd);
			if (done) board.check_direction(result);
			if ((start && !busy) || done) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	// Drive one beat after random idle gaps with start low; hold start until busy drops.
	task automatic send_hit(cmd_t h);
		while ($urandom_range(99) < send_gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= h;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic pause_sender();
		start <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	function automatic cmd_t random_hit();
		cmd_t h;
		h = cmd_t'({$urandom, $urandom, $urandom, $urandom});
		// Mostly components within [-1, 1] and valid cosines so both branches get real work.
		if ($urandom_range(3) != 0) begin
			h.cos_incidence = 16'($signed($urandom_range(32768)) - 16384);
			h.refr_index    = 15'($urandom_range(32767, 8192));
			h.normal_x = 16'($signed($urandom_range(32768)) - 16384);
			h.normal_y = 16'($signed($urandom_range(32768)) - 16384);
			h.normal_z = 16'($signed($urandom_range(32768)) - 16384);
			h.dir_x    = 16'($signed($urandom_range(32768)) - 16384);
			h.dir_y    = 16'($signed($urandom_range(32768)) - 16384);
			h.dir_z    = 16'($signed($urandom_range(32768)) - 16384);
		end
		return h;
	endfunction

	function automatic cmd_t make_hit(logic m, logic signed [15:0] n, logic signed [15:0] d,
		logic signed [15:0] c, logic [14:0] idx);
		cmd_t h;
		h = '{m, n, -n, n, d, d, -d, c, idx};
		return h;
	endfunction

	initial begin
		board = new();
		start = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		idle_cycles = 0;
		timed_out = 1'b0;
		send_gap_pct = 18;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, both modes, both crossing sides, total reflection,
		// zero and tiny index (ratio saturates), component saturation.
		send_hit(make_hit(mode_reflect, 16'sh7fff, 16'sh7fff, -16'sd16384, 15'd8192));
		send_hit(make_hit(mode_reflect, -16'sh8000, -16'sh8000, 16'sd16384, 15'h7fff));
		send_hit(make_hit(mode_reflect, 16'sd0, 16'sd16384, 16'sd0, 15'd0));
		send_hit(make_hit(mode_refract, 16'sd16384, -16'sd16384, -16'sd16384, 15'd8192));
		send_hit(make_hit(mode_refract, 16'sd16384, 16'sd11585, -16'sd11585, 15'd12288));
		send_hit(make_hit(mode_refract, 16'sd16384, 16'sd11585, 16'sd11585, 15'd12288));
		send_hit(make_hit(mode_refract, 16'sd16384, 16'sd16000, 16'sd2000, 15'd24576));
		send_hit(make_hit(mode_refract, 16'sd16384, 16'sd16384, 16'sd0, 15'h7fff));
		send_hit(make_hit(mode_refract, 16'sd16384, 16'sd16384, -16'sd1, 15'd0));
		send_hit(make_hit(mode_refract, 16'sd16384, 16'sd16384, -16'sd100, 15'd1));
		send_hit(make_hit(mode_refract, 16'sd16384, 16'sd16384, -16'sd8000, 15'd4000));
		send_hit(make_hit(mode_refract, 16'sh7fff, 16'sh7fff, 16'sd16384, 15'h7fff));
		send_hit(make_hit(mode_refract, -16'sh8000, 16'sh7fff, -16'sh8000, 15'd8192));
		send_hit(make_hit(mode_refract, 16'sh7fff, -16'sh8000, 16'sh7fff, 15'h7fff));
		pause_sender();

		for (int i = 0; i < 650; i++) begin
			if (i == 220) send_gap_pct = 87;
			if (i == 330) send_gap_pct = 0;
			if (i == 300) pause_sender();
			send_hit(random_hit());
		end
		start <= 1'b0;

		while (board.pending.size() != 0 && !timed_out) @(posedge clk);
		repeat (30) @(posedge clk);
		if (board.errors == 0 && !timed_out)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Watchdog: end the run if nothing moves for too long.
	always @(posedge clk) begin
		if (idle_cycles > STALL_LIMIT && board.pending.size() != 0) begin
			timed_out = 1'b1;
			$display("Some tests failed");
			$finish;
		end
	end
endmodule

[ray_reflect_refract_direction.f]
src/rrd_pkg.sv
src/ray_reflect_refract_direction.sv
dv/tb.sv
